@@ rtl/wwt_pkg.sv @@
// Package for the work-RAM write watchpoint trace block.
// Holds the sizes, item codes, log entry type and the bus address map.
// Depends on nothing; used by wwt_log_ram, wram_write_watchpoint_trace and the testbench.
`default_nettype none

package wwt_pkg;

    localparam int RANGE_SLOTS = 8;
    localparam int LOG_DEPTH   = 16384;
    localparam int LOG_AW      = $clog2(LOG_DEPTH);
    localparam int HELD_W      = LOG_AW + 1;
    localparam int RS_W        = $clog2(RANGE_SLOTS + 1);
    localparam int RS_IDX_W    = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
    localparam int OFF_W       = 17;

    localparam logic [7:0]  BANK_WRAM_LO  = 8'h7E;
    localparam logic [7:0]  BANK_WRAM_HI  = 8'h7F;
    localparam logic [7:0]  BANK_LOW_MAX  = 8'h3F;
    localparam logic [7:0]  BANK_HIGH_MIN = 8'h80;
    localparam logic [7:0]  BANK_HIGH_MAX = 8'hBF;
    localparam logic [15:0] MIRROR_MAX    = 16'h1FFF;
    localparam logic [23:0] WRAM_SIZE     = 24'h020000;

    typedef enum logic [2:0] {
        MODE_WRITE = 3'd0,
        MODE_ADD   = 3'd1,
        MODE_CLEAR = 3'd2,
        MODE_READ  = 3'd3,
        MODE_TICK  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FILTERED  = 2'd1,
        ST_BAD_RANGE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0]      frame;
        logic [OFF_W-1:0] addr;
        logic [23:0]      pc;
        logic [7:0]       prev_val;
        logic [7:0]       new_val;
        logic [7:0]       bank;
    } log_entry_t;

    typedef struct packed {
        logic             hit;
        logic [OFF_W-1:0] off;
    } wram_map_t;

    function automatic wram_map_t map_to_wram(input logic [23:0] addr);
        logic [7:0]  bank;
        logic [15:0] off;
        wram_map_t   res;
        bank = addr[23:16];
        off  = addr[15:0];
        res.hit = 1'b1;
        res.off = {1'b0, off};
        if (bank == BANK_WRAM_LO) begin
            res.off = {1'b0, off};
        end else if (bank == BANK_WRAM_HI) begin
            res.off = {1'b1, off};
        end else if (off <= MIRROR_MAX && (bank <= BANK_LOW_MAX ||
                     (bank >= BANK_HIGH_MIN && bank <= BANK_HIGH_MAX))) begin
            res.off = {1'b0, off};
        end else begin
            res.hit = 1'b0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/wwt_log_ram.sv @@
// Trace ring storage: one write port and one read port with registered data.
// Depends on wwt_pkg for the entry type and the ring depth.
`default_nettype none

module wwt_log_ram (
    input  wire                        aclk,
    input  wire                        wr_en,
    input  wire  [wwt_pkg::LOG_AW-1:0] wr_addr,
    input  wwt_pkg::log_entry_t        wr_data,
    input  wire                        rd_en,
    input  wire  [wwt_pkg::LOG_AW-1:0] rd_addr,
    output wwt_pkg::log_entry_t        rd_data
);
    import wwt_pkg::*;

    log_entry_t mem [LOG_DEPTH];
    log_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/wram_write_watchpoint_trace.sv @@
// Top level of the work-RAM write watchpoint trace block.
// Holds the range table, ring pointers and result register; uses wwt_pkg and wwt_log_ram.
//
//   Channel   Ports                          Word
//   input     s_tvalid s_tready s_tdata      one item, s_tuser gives the mode
//   result    m_tvalid m_tready m_tdata      one result word per input word
//
// Every item is handled in two steps: the accept cycle updates the state and starts the ring
// read, and the next cycle loads the result register from the registered read data.
// A new word is taken while the previous result is being taken in the same cycle.
// Reset clears the counters and pointers; the ring and the range table hold no reset.
// A stall on the result side holds the result register and stops input acceptance.
`default_nettype none

module wram_write_watchpoint_trace (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // cpu_addr[23:0], write_byte[31:24], old_byte[39:32], cpu_pc[63:40],
    // range_lo[87:64], range_hi[111:88], entry_index[127:112]
    input  wire  [127:0] s_tdata,
    // mode[2:0]
    input  wire  [2:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // status[1:0], range_count[5:2], log_count[20:6], out_frame[52:21],
    // out_addr[69:53], out_pc[93:70], prev_byte[101:94], new_byte[109:102],
    // out_bank[117:110], zero fill[119:118]
    output logic [119:0] m_tdata
);
    import wwt_pkg::*;

    logic [23:0] cpu_addr;
    logic [7:0]  write_byte;
    logic [7:0]  old_byte;
    logic [23:0] cpu_pc;
    logic [23:0] range_lo;
    logic [23:0] range_hi;
    logic [15:0] entry_index;
    mode_t       mode;

    assign cpu_addr    = s_tdata[23:0];
    assign write_byte  = s_tdata[31:24];
    assign old_byte    = s_tdata[39:32];
    assign cpu_pc      = s_tdata[63:40];
    assign range_lo    = s_tdata[87:64];
    assign range_hi    = s_tdata[111:88];
    assign entry_index = s_tdata[127:112];
    assign mode        = mode_t'(s_tuser);

    logic [31:0]       frame_count_reg;
    logic [RS_W-1:0]   ranges_used_reg;
    logic [LOG_AW-1:0] write_pointer_reg;
    logic [HELD_W-1:0] entries_held_reg;
    logic [OFF_W-1:0]  range_low_reg  [RANGE_SLOTS];
    logic [OFF_W-1:0]  range_high_reg [RANGE_SLOTS];

    logic       pend_reg;
    logic       pend_rd_ok_reg;
    status_t    pend_status_reg;
    logic       m_tvalid_reg;
    logic [119:0] m_tdata_reg;

    logic       accept;
    wram_map_t  map;
    logic       range_hit;
    logic       log_write;
    logic       add_ok;
    logic       rd_ok;
    status_t    status_next;
    logic [LOG_AW-1:0] rd_start;
    logic [LOG_AW-1:0] rd_addr;
    log_entry_t wr_entry;
    log_entry_t rd_entry;
    log_entry_t out_entry;

    assign s_tready = !pend_reg && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign map      = map_to_wram(cpu_addr);

    always_comb begin
        range_hit = 1'b0;
        for (int k = 0; k < RANGE_SLOTS; k++) begin
            if (RS_W'(k) < ranges_used_reg && map.off >= range_low_reg[k] &&
                map.off <= range_high_reg[k]) begin
                range_hit = 1'b1;
            end
        end
    end

    assign rd_start = (entries_held_reg < HELD_W'(LOG_DEPTH)) ? '0 : write_pointer_reg;
    assign rd_addr  = rd_start + entry_index[LOG_AW-1:0];

    always_comb begin
        log_write   = 1'b0;
        add_ok      = 1'b0;
        rd_ok       = 1'b0;
        status_next = ST_DONE;
        unique case (mode)
            MODE_WRITE: begin
                if (map.hit && range_hit) begin
                    log_write = 1'b1;
                end else begin
                    status_next = ST_FILTERED;
                end
            end
            MODE_ADD: begin
                if (range_lo > range_hi || range_hi >= WRAM_SIZE) begin
                    status_next = ST_BAD_RANGE;
                end else if (ranges_used_reg >= RS_W'(RANGE_SLOTS)) begin
                    status_next = ST_FULL;
                end else begin
                    add_ok = 1'b1;
                end
            end
            MODE_READ: begin
                if (17'(entry_index) >= 17'(entries_held_reg)) begin
                    status_next = ST_FILTERED;
                end else begin
                    rd_ok = 1'b1;
                end
            end
            default: begin
                status_next = ST_DONE;
            end
        endcase
    end

    assign wr_entry.frame    = frame_count_reg;
    assign wr_entry.addr     = map.off;
    assign wr_entry.pc       = cpu_pc;
    assign wr_entry.prev_val = old_byte;
    assign wr_entry.new_val  = write_byte;
    assign wr_entry.bank     = cpu_addr[23:16];

    wwt_log_ram u_log_ram (
        .aclk    (aclk),
        .wr_en   (accept && log_write),
        .wr_addr (write_pointer_reg),
        .wr_data (wr_entry),
        .rd_en   (accept && rd_ok),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    always_ff @(posedge aclk) begin
        if (accept && add_ok) begin
            range_low_reg[ranges_used_reg[RS_IDX_W-1:0]]  <= range_lo[OFF_W-1:0];
            range_high_reg[ranges_used_reg[RS_IDX_W-1:0]] <= range_hi[OFF_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg   <= '0;
            ranges_used_reg   <= '0;
            write_pointer_reg <= '0;
            entries_held_reg  <= '0;
        end else if (accept) begin
            if (log_write) begin
                write_pointer_reg <= write_pointer_reg + LOG_AW'(1);
                if (entries_held_reg < HELD_W'(LOG_DEPTH)) begin
                    entries_held_reg <= entries_held_reg + HELD_W'(1);
                end
            end
            if (add_ok) begin
                ranges_used_reg <= ranges_used_reg + RS_W'(1);
            end
            if (mode == MODE_CLEAR) begin
                ranges_used_reg   <= '0;
                write_pointer_reg <= '0;
                entries_held_reg  <= '0;
            end
            if (mode == MODE_TICK) begin
                frame_count_reg <= frame_count_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_rd_ok_reg  <= rd_ok;
            pend_status_reg <= status_next;
        end
    end

    assign out_entry = pend_rd_ok_reg ? rd_entry : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pend_reg <= accept;
            if (pend_reg) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            m_tdata_reg <= {2'b00, out_entry.bank, out_entry.new_val, out_entry.prev_val,
                            out_entry.pc, out_entry.addr, out_entry.frame,
                            15'(entries_held_reg), 4'(ranges_used_reg), pend_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ verif/tb_wram_write_watchpoint_trace.sv @@
// Testbench for the work-RAM write watchpoint trace block with its own model of ranges and ring.
// Drives random and directed words with random idling; depends on wwt_pkg and the block's RTL.
`default_nettype none

module tb_wram_write_watchpoint_trace;
    import wwt_pkg::*;

    localparam logic [2:0] MODE_SPARE_MAX = 3'd7;

    typedef struct {
        logic [2:0]  mode;
        logic [23:0] cpu_addr;
        logic [7:0]  wbyte;
        logic [7:0]  obyte;
        logic [23:0] pc;
        logic [23:0] lo;
        logic [23:0] hi;
        logic [15:0] idx;
    } bus_item_t;

    typedef struct packed {
        logic [31:0]      frame;
        logic [OFF_W-1:0] offset;
        logic [23:0]      pc;
        logic [7:0]       old_b;
        logic [7:0]       new_b;
        logic [7:0]       bank;
    } trace_entry_t;

    typedef struct packed {
        status_t           status;
        logic [3:0]        ranges;
        logic [HELD_W-1:0] held;
        trace_entry_t      entry;
    } trace_result_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;

    wram_write_watchpoint_trace i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bus_item_t     pending_items[$];
    trace_result_t expected_results[$];
    bus_item_t     next_item;
    trace_result_t oldest;

    logic [31:0]        frame_cnt = '0;
    logic [OFF_W-1:0]   win_lo [RANGE_SLOTS];
    logic [OFF_W-1:0]   win_hi [RANGE_SLOTS];
    logic [3:0]         win_used = '0;
    logic [LOG_AW-1:0]  ring_wr = '0;
    logic [HELD_W-1:0]  ring_held = '0;
    trace_entry_t       ring_mem [LOG_DEPTH];

    int accepted_items = 0;
    int offered_items = 0;
    int mismatches = 0;
    int cycles = 0;
    int cycle_limit = 0;
    int tx_gap = 0;
    int rx_stall = 0;
    bit tx_quiet = 0;
    bit rx_quiet = 0;
    bit hold_rx = 0;

    // Shadow of the ranges and log size used only to steer the stimulus.
    int gen_lo[$];
    int gen_hi[$];
    int gen_held = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int idle_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Predicts the result word of one accepted input word and updates the model state.
    function automatic trace_result_t trace_step(input logic [2:0] mode, input logic [127:0] d);
        trace_result_t     r;
        logic [23:0]       addr;
        logic [23:0]       lo;
        logic [23:0]       hi;
        logic [15:0]       idx;
        logic [7:0]        bank;
        logic              mapped;
        logic              matched;
        logic [OFF_W-1:0]  off;
        logic [LOG_AW-1:0] slot;
        r = '0;
        r.status = ST_DONE;
        addr = d[23:0];
        lo = d[87:64];
        hi = d[111:88];
        idx = d[127:112];
        bank = addr[23:16];
        case (mode)
            MODE_WRITE: begin
                mapped = 1'b1;
                off = {1'b0, addr[15:0]};
                if (bank == BANK_WRAM_HI) begin
                    off[16] = 1'b1;
                end else if (bank != BANK_WRAM_LO && !(addr[15:0] <= MIRROR_MAX &&
                             (bank <= BANK_LOW_MAX ||
                              (bank >= BANK_HIGH_MIN && bank <= BANK_HIGH_MAX)))) begin
                    mapped = 1'b0;
                end
                matched = 1'b0;
                for (int k = 0; k < RANGE_SLOTS; k++) begin
                    if (k < win_used && off >= win_lo[k] && off <= win_hi[k]) matched = 1'b1;
                end
                if (mapped && matched) begin
                    ring_mem[ring_wr] = {frame_cnt, off, d[63:40], d[39:32], d[31:24], bank};
                    ring_wr = ring_wr + 1'b1;
                    if (ring_held < LOG_DEPTH) ring_held = ring_held + 1'b1;
                end else begin
                    r.status = ST_FILTERED;
                end
            end
            MODE_ADD: begin
                if (lo > hi || hi >= WRAM_SIZE) begin
                    r.status = ST_BAD_RANGE;
                end else if (win_used >= RANGE_SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    win_lo[win_used] = lo[OFF_W-1:0];
                    win_hi[win_used] = hi[OFF_W-1:0];
                    win_used = win_used + 1'b1;
                end
            end
            MODE_CLEAR: begin
                win_used = '0;
                ring_wr = '0;
                ring_held = '0;
            end
            MODE_READ: begin
                if (idx >= ring_held) begin
                    r.status = ST_FILTERED;
                end else begin
                    slot = (ring_held < LOG_DEPTH) ? '0 : ring_wr;
                    slot = slot + idx[LOG_AW-1:0];
                    r.entry = ring_mem[slot];
                end
            end
            MODE_TICK: begin
                frame_cnt = frame_cnt + 1'b1;
            end
            default: begin
            end
        endcase
        r.ranges = win_used;
        r.held = ring_held;
        return r;
    endfunction

    task automatic queue_item(input int mode, input int addr, input int lo, input int hi,
                              input int idx);
        bus_item_t it;
        it.mode = mode[2:0];
        it.cpu_addr = addr[23:0];
        it.wbyte = 8'($urandom);
        it.obyte = 8'($urandom);
        it.pc = 24'($urandom);
        it.lo = lo[23:0];
        it.hi = hi[23:0];
        it.idx = idx[15:0];
        pending_items.push_back(it);
    endtask

    function automatic logic [23:0] bus_for_offset(input int off);
        logic [7:0] bank;
        if (off >= 'h10000) return {BANK_WRAM_HI, off[15:0]};
        if (off <= MIRROR_MAX && $urandom_range(0, 1) == 1) begin
            if ($urandom_range(0, 1) == 1) bank = 8'($urandom_range(0, BANK_LOW_MAX));
            else bank = 8'($urandom_range(BANK_HIGH_MIN, BANK_HIGH_MAX));
            return {bank, off[15:0]};
        end
        return {BANK_WRAM_LO, off[15:0]};
    endfunction

    task automatic gen_sessions(input int budget);
        int made;
        int pick;
        int lo;
        int hi;
        int k;
        int n;
        made = 0;
        while (made < budget) begin
            if ($urandom_range(0, 3) != 0) begin
                queue_item(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
                gen_lo.delete();
                gen_hi.delete();
                gen_held = 0;
                made++;
            end
            n = $urandom_range(1, RANGE_SLOTS + 1);
            for (int a = 0; a < n; a++) begin
                pick = $urandom_range(0, 99);
                lo = $urandom_range(0, WRAM_SIZE - 1);
                if (pick < 80) begin
                    hi = lo + $urandom_range(0, (pick < 40) ? 64 : 8192);
                    if (hi >= WRAM_SIZE) hi = WRAM_SIZE - 1;
                    queue_item(MODE_ADD, $urandom, lo, hi, $urandom);
                    if (gen_lo.size() < RANGE_SLOTS) begin
                        gen_lo.push_back(lo);
                        gen_hi.push_back(hi);
                    end
                end else if (pick < 90) begin
                    queue_item(MODE_ADD, $urandom, $urandom, $urandom, $urandom);
                end else begin
                    queue_item(MODE_ADD, $urandom, lo + $urandom_range(1, 100), lo, $urandom);
                end
                made++;
            end
            n = $urandom_range(10, 60);
            for (int o = 0; o < n; o++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    if (gen_lo.size() > 0 && $urandom_range(0, 9) != 0) begin
                        k = $urandom_range(0, gen_lo.size() - 1);
                        lo = gen_lo[k] + $urandom_range(0, gen_hi[k] - gen_lo[k]);
                        queue_item(MODE_WRITE, bus_for_offset(lo), $urandom, $urandom, $urandom);
                        gen_held++;
                    end else begin
                        queue_item(MODE_WRITE, $urandom, $urandom, $urandom, $urandom);
                    end
                end else if (pick < 65) begin
                    queue_item(MODE_TICK, $urandom, $urandom, $urandom, $urandom);
                end else if (pick < 90) begin
                    if (gen_held > 0 && pick < 85)
                        k = $urandom_range(0, gen_held - 1);
                    else if (pick < 87)
                        k = gen_held;
                    else
                        k = $urandom;
                    queue_item(MODE_READ, $urandom, $urandom, $urandom, k);
                end else if (pick < 95) begin
                    queue_item(MODE_ADD, $urandom, $urandom_range(0, 'h1FF00),
                               $urandom_range('h1FF00, WRAM_SIZE), $urandom);
                end else begin
                    queue_item($urandom_range(MODE_TICK + 1, MODE_SPARE_MAX), $urandom,
                               $urandom, $urandom, $urandom);
                end
                made++;
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;

        // Directed: filtering with no ranges, range checks, a full table and the address map.
        queue_item(MODE_WRITE, 24'h7E1234, $urandom, $urandom, $urandom);
        queue_item(MODE_READ, $urandom, $urandom, $urandom, 0);
        queue_item(MODE_ADD, $urandom, 24'h000005, 24'h000004, $urandom);
        queue_item(MODE_ADD, $urandom, 24'h000000, WRAM_SIZE, $urandom);
        queue_item(MODE_ADD, $urandom, 24'hFFFFFF, 24'hFFFFFF, $urandom);
        queue_item(MODE_ADD, $urandom, 24'h000000, WRAM_SIZE - 1, $urandom);
        for (int k = 1; k < RANGE_SLOTS; k++)
            queue_item(MODE_ADD, $urandom, k * 'h100, k * 'h100 + 'hF, $urandom);
        queue_item(MODE_ADD, $urandom, 24'h000010, 24'h000020, $urandom);
        queue_item(MODE_ADD, $urandom, 24'h000030, 24'h000020, $urandom);
        queue_item(MODE_WRITE, 24'h000000, $urandom, $urandom, $urandom);
        queue_item(MODE_WRITE, 24'h7EFFFF, $urandom, $urandom, $urandom);
        queue_item(MODE_WRITE, 24'h7F0000, $urandom, $urandom, $urandom);
        queue_item(MODE_TICK, $urandom, $urandom, $urandom, $urandom);
        queue_item(MODE_WRITE, 24'h7FFFFF, $urandom, $urandom, $urandom);
        queue_item(MODE_WRITE, 24'h002000, $urandom, $urandom, $urandom);
        queue_item(MODE_WRITE, 24'hBF1FFF, $urandom, $urandom, $urandom);
        queue_item(MODE_WRITE, 24'hC00000, $urandom, $urandom, $urandom);
        queue_item(MODE_WRITE, 24'hFFFFFF, $urandom, $urandom, $urandom);
        queue_item(MODE_READ, $urandom, $urandom, $urandom, 0);
        queue_item(MODE_READ, $urandom, $urandom, $urandom, 16'hFFFF);
        queue_item(MODE_SPARE_MAX, $urandom, $urandom, $urandom, $urandom);
        queue_item(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
        queue_item(MODE_READ, $urandom, $urandom, $urandom, 0);

        gen_sessions(400);
        gen_sessions(400);
        cycle_limit = 1000 * pending_items.size() + 50000;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || accepted_items != offered_items) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[wram_write_watchpoint_trace] OK");
        end else begin
            $display("[wram_write_watchpoint_trace] ERROR");
        end
        $finish;
    end

    // The receiver holds off for a long stretch so that the block backs up into its input.
    initial begin
        while (accepted_items < 200) @(posedge aclk);
        hold_rx = 1'b1;
        repeat (400) @(posedge aclk);
        hold_rx = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > cycle_limit && cycle_limit != 0) begin
            $display("[wram_write_watchpoint_trace] ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (aresetn && accepted_items == offered_items) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                next_item = pending_items.pop_front();
                s_tuser <= next_item.mode;
                s_tdata <= {next_item.idx, next_item.hi, next_item.lo, next_item.pc,
                            next_item.obyte, next_item.wbyte, next_item.cpu_addr};
                s_tvalid <= 1'b1;
                offered_items++;
                if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
                tx_gap = idle_len(tx_quiet);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn || hold_rx) begin
            m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 63) == 0) rx_quiet = !rx_quiet;
            rx_stall = idle_len(rx_quiet);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_results.push_back(trace_step(s_tuser, s_tdata));
            accepted_items++;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result word %h arrived with no item waiting", m_tdata);
                mismatches++;
            end else begin
                oldest = expected_results.pop_front();
                check_field("status", oldest.status, m_tdata[1:0]);
                check_field("range_count", oldest.ranges, m_tdata[5:2]);
                check_field("log_count", oldest.held, m_tdata[20:6]);
                check_field("out_frame", oldest.entry.frame, m_tdata[52:21]);
                check_field("out_addr", oldest.entry.offset, m_tdata[69:53]);
                check_field("out_pc", oldest.entry.pc, m_tdata[93:70]);
                check_field("prev_byte", oldest.entry.old_b, m_tdata[101:94]);
                check_field("new_byte", oldest.entry.new_b, m_tdata[109:102]);
                check_field("out_bank", oldest.entry.bank, m_tdata[117:110]);
            end
        end
    end

endmodule

`default_nettype wire
